>>> design/double_ended_queue_macros.svh
// Assertion shorthands for the deque checker.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

>>> design/dq_pkg.sv
package dq_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = CNT_W + 1;

  typedef enum logic [2:0] {
    OP_INIT       = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_PUSH_REAR  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_REAR   = 3'd4,
    OP_PEEK_FRONT = 3'd5,
    OP_PEEK_REAR  = 3'd6,
    OP_DESTROY    = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;     // latch the request
    logic exec;     // carry out the request
    logic capture;  // take the read word from the slot store
  } dq_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_read;  // a successful peek waits for the slot store
  } dq_stat_t;

endpackage

>>> design/dq_ram.sv
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/dq_ctrl.sv
module dq_ctrl
  import dq_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dq_stat_t stat_i,
  output dq_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = start_i;
        if (start_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = stat_i.need_read ? S_READ : S_DONE;
      end
      S_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

>>> design/dq_dpath.sv
module dq_dpath
  import dq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dq_cmd_t                  cmd_i,
  input  logic [2:0]               op_i,
  input  logic signed [DATA_W-1:0] value_i,
  output dq_stat_t                 stat_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic [COUNT_W-1:0]       count_o
);

  op_e                     op_q;
  logic [DATA_W-1:0]       value_q;
  logic [IDX_W-1:0]        front_q, front_d;
  logic [CNT_W-1:0]        fill_q, fill_d;
  logic                    ready_q, ready_d;
  status_e                 status_q, status_d;
  logic [DATA_W-1:0]       data_q;

  logic                    full;
  logic                    empty;
  logic [IDX_W-1:0]        front_dec;
  logic [IDX_W-1:0]        front_inc;
  logic [SUM_W-1:0]        rear_sum;
  logic [SUM_W-1:0]        last_sum;
  logic [IDX_W-1:0]        rear_pos;
  logic [IDX_W-1:0]        last_pos;

  logic                    we;
  logic [IDX_W-1:0]        waddr;
  logic [IDX_W-1:0]        raddr;
  logic [WORD_BITS-1:0]    rdata;

  assign full  = (fill_q == CNT_W'(DEPTH));
  assign empty = (fill_q == '0);

  assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
  assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + IDX_W'(1);

  // Ring positions: one compare and subtract folds the sum back into range.
  assign rear_sum = SUM_W'(front_q) + SUM_W'(fill_q);
  assign last_sum = rear_sum - SUM_W'(1);
  assign rear_pos = (rear_sum >= SUM_W'(DEPTH)) ? IDX_W'(rear_sum - SUM_W'(DEPTH))
                                                : IDX_W'(rear_sum);
  assign last_pos = (last_sum >= SUM_W'(DEPTH)) ? IDX_W'(last_sum - SUM_W'(DEPTH))
                                                : IDX_W'(last_sum);

  always_comb begin
    front_d          = front_q;
    fill_d           = fill_q;
    ready_d          = ready_q;
    status_d         = ST_OK;
    we               = 1'b0;
    waddr            = rear_pos;
    raddr            = front_q;
    stat_o.need_read = 1'b0;
    priority if (op_q == OP_INIT) begin
      front_d = '0;
      fill_d  = '0;
      ready_d = 1'b1;
    end else if (!ready_q) begin
      status_d = ST_NOT_INIT;
    end else if (op_q == OP_DESTROY) begin
      front_d = '0;
      fill_d  = '0;
      ready_d = 1'b0;
    end else if (op_q == OP_PUSH_FRONT || op_q == OP_PUSH_REAR) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        we     = 1'b1;
        fill_d = fill_q + CNT_W'(1);
        if (op_q == OP_PUSH_FRONT) begin
          front_d = front_dec;
          waddr   = front_dec;
        end
      end
    end else if (empty) begin
      status_d = ST_EMPTY;
    end else begin
      unique case (op_q)
        OP_POP_FRONT: begin
          front_d = front_inc;
          fill_d  = fill_q - CNT_W'(1);
        end
        OP_POP_REAR: begin
          fill_d = fill_q - CNT_W'(1);
        end
        OP_PEEK_FRONT: begin
          stat_o.need_read = 1'b1;
        end
        OP_PEEK_REAR: begin
          raddr            = last_pos;
          stat_o.need_read = 1'b1;
        end
        default: begin
          status_d = ST_OK;
        end
      endcase
    end
  end

  dq_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_dq_ram (
    .clk_i   (clk_i),
    .we_i    (we && cmd_i.exec),
    .waddr_i (waddr),
    .wdata_i (WORD_BITS'($unsigned(value_q))),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Request and result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(op_i);
      value_q <= value_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      data_q   <= '0;
    end else if (cmd_i.capture) begin
      data_q <= DATA_W'($signed(rdata));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      fill_q  <= '0;
      ready_q <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      fill_q  <= fill_d;
      ready_q <= ready_d;
    end
  end

  assign status_o   = status_q;
  assign data_o     = data_q;
  assign is_empty_o = empty;
  assign is_full_o  = full;
  assign count_o    = COUNT_W'(fill_q);

endmodule

>>> design/double_ended_queue.sv
// Bounded double-ended queue of signed words, held in a ring of DEPTH slots.
//
// Request channel: drive op_i and value_i with start high; the request is
// taken at a rising edge where start is high and busy is low. busy stays high
// until the result has been shown, so hold start low or ignore it meanwhile.
// Result channel: done_o marks the single cycle in which status_o, data_o,
// is_empty_o, is_full_o and count_o are valid. The receiver cannot hold
// results off; capture them in that cycle.
//
// Sequence: the request is registered at the accepting edge, the execute
// state applies it and registers the result, and done_o rises in the
// result state; a successful peek first passes through a read state, which
// waits on the registered read port of the slot memory. The controller
// walks accept, execute, optional read and result states and takes the
// next request only when back in idle.
//
// Reset clears the controller, the ring pointers and the initialized flag.
// The slot memory is not cleared: every slot is written by a push before a
// peek can read it. Any request other than init before init returns not-initialized.
module double_ended_queue
  import dq_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               op_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic                     is_empty_o,
  output logic                     is_full_o,
  output logic [COUNT_W-1:0]       count_o
);

  // Commands flow from the controller, a single status bit flows back.
  dq_cmd_t  cmd;
  dq_stat_t stat;

  // Sequence each transaction: accept, execute, optionally wait on the
  // slot read, then present the result for one cycle.
  dq_ctrl u_dq_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // Hold the ring pointers, the fill count, the slot memory and the result.
  dq_dpath u_dq_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (op_i),
    .value_i    (value_i),
    .stat_o     (stat),
    .status_o   (status_o),
    .data_o     (data_o),
    .is_empty_o (is_empty_o),
    .is_full_o  (is_full_o),
    .count_o    (count_o)
  );

endmodule

>>> design/dq_checker.sv
`include "double_ended_queue_macros.svh"

module dq_checker
  import dq_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic [2:0]               op_i,
  input logic signed [DATA_W-1:0] value_i,
  input logic                     done_o,
  input logic [1:0]               status_o,
  input logic signed [DATA_W-1:0] data_o,
  input logic                     is_empty_o,
  input logic                     is_full_o,
  input logic [COUNT_W-1:0]       count_o
);

  logic unused_ok;
  assign unused_ok = ^{op_i, value_i};

  `DQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done_o)
  `DQ_ASSERT_NOW(a_done_in_busy, done_o, busy)
  `DQ_ASSERT_NEXT(a_done_pulse, done_o, !done_o)
  `DQ_ASSERT_NOW(a_flags_count, done_o, (is_empty_o == (count_o == '0)) && (is_full_o == (count_o == COUNT_W'(DEPTH))))
  `DQ_ASSERT_NOW(a_fail_no_data, done_o && status_o != ST_OK, data_o == '0)

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);
